/* sv/mcr_pkg.sv */
// Shared types, constants and control structs of the match conflict resolver.
package mcr_pkg;

  // Fixed field widths of the item channels
  localparam int FEAT_W  = 12;
  localparam int ELEMP_W = 6;
  localparam int VALUE_W = 16;
  localparam int MODE_W  = 3;
  localparam int ACC_W   = 64;
  localparam int MAP_W   = FEAT_W + 1;  // valid bit over first-image index

  // Defaults for the top-level parameters
  localparam int MAX_FEATURES_DEF = 4096;
  localparam int DESC_LEN_DEF     = 64;
  localparam int ELEM_BITS_DEF    = 16;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_LOAD_FIRST   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_SECOND  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR_MAP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST_MATCH  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SECOND_MATCH = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RECHECK      = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [FEAT_W-1:0]         first_feature;
    logic [FEAT_W-1:0]         second_feature;
    logic [ELEMP_W-1:0]        element;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              keep;
    logic              which_list;
    logic [FEAT_W-1:0] out_first;
    logic [FEAT_W-1:0] out_second;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic prep;
    logic wr_first;
    logic wr_second;
    logic map_set;
    logic map_clr;
    logic sweep;
    logic acc_clr;
    logic dot_step;
    logic out_load;
    logic out_keep;
    logic out_which;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              f1_ok;
    logic              f2_ok;
    logic              el_ok;
    logic              map_valid;
    logic              map_same;
    logic              k_last;
    logic              pipe_busy;
    logic              sweep_last;
    logic              greater;
    logic              out_free;
  } ctl_stat_t;

endpackage

/* sv/match_conflict_resolver.sv */
// Top level of the match conflict resolver: sequencer plus datapath.
//
// The block judges feature matches between a first and a second image. Beats
// on the input channel carry a mode: load one descriptor element of either
// image, clear the second-to-first map, record a first-list match, judge a
// second-list match, or recheck a first-list match. Only the last two give a
// result beat. One item is worked on at a time. A load or first-list match
// goes through a prep state and a write state before the next accept; a
// recheck, or a second-list match that needs no judging (empty map entry or
// same first feature), goes through prep, map read and result, the last
// waiting for the output handoff. A second-list match that hits a different
// mapped feature is judged: two multiply-accumulate lanes walk both
// descriptors one element per cycle, fed by the dual read ports of the
// first-descriptor memory and one port of the second-descriptor memory,
// then a short drain and the compare. A clear-map item sweeps the map one
// entry per cycle; the same sweep runs after reset, so no item is taken
// before it ends. Descriptor memories are not cleared: read only descriptors
// you loaded. The result beat sits in an output register, so a new item is
// taken while a finished result still waits for the consumer.
module match_conflict_resolver #(
  parameter int MAX_FEATURES = mcr_pkg::MAX_FEATURES_DEF,
  parameter int DESC_LEN     = mcr_pkg::DESC_LEN_DEF,
  parameter int ELEM_BITS    = mcr_pkg::ELEM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  mcr_pkg::in_item_t  in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output mcr_pkg::out_item_t out_data
);

  mcr_pkg::ctl_cmd_t  cmd;   // sequencer commands
  mcr_pkg::ctl_stat_t stat;  // datapath status

  mcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcr_datapath #(
    .MAX_FEATURES (MAX_FEATURES),
    .DESC_LEN     (DESC_LEN),
    .ELEM_BITS    (ELEM_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/mcr_ram.sv */
// Generic single-write, dual-read RAM with registered read data.
module mcr_ram #(
  parameter int WIDTH = mcr_pkg::ELEM_BITS_DEF,
  parameter int DEPTH = mcr_pkg::MAX_FEATURES_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

/* sv/mcr_ctrl.sv */
// Sequencer of the match conflict resolver: steps each item through its phases.
module mcr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcr_pkg::ctl_stat_t stat,
  output mcr_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_MAP_SET,
    ST_MAP_RD,
    ST_DOT_RUN,
    ST_DOT_DRAIN,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   keep_r, keep_nxt;
  logic   which_r, which_nxt;
  logic   hit;

  assign hit      = stat.f2_ok && stat.map_valid;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    keep_nxt      = keep_r;
    which_nxt     = which_r;
    cmd.out_keep  = keep_r;
    cmd.out_which = which_r;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        unique case (stat.mode) inside
          mcr_pkg::MODE_LOAD_FIRST, mcr_pkg::MODE_LOAD_SECOND: state_nxt = ST_LOAD;
          mcr_pkg::MODE_CLEAR_MAP:                             state_nxt = ST_SWEEP;
          mcr_pkg::MODE_FIRST_MATCH:                           state_nxt = ST_MAP_SET;
          mcr_pkg::MODE_SECOND_MATCH, mcr_pkg::MODE_RECHECK:   state_nxt = ST_MAP_RD;
          default:                                             state_nxt = ST_IDLE;
        endcase
      end
      ST_LOAD: begin
        cmd.wr_first  = (stat.mode == mcr_pkg::MODE_LOAD_FIRST) && stat.f1_ok && stat.el_ok;
        cmd.wr_second = (stat.mode == mcr_pkg::MODE_LOAD_SECOND) && stat.f2_ok && stat.el_ok;
        state_nxt     = ST_IDLE;
      end
      ST_MAP_SET: begin
        cmd.map_set = stat.f2_ok;
        state_nxt   = ST_IDLE;
      end
      ST_MAP_RD: begin
        cmd.acc_clr = 1'b1;
        if (stat.mode == mcr_pkg::MODE_RECHECK) begin
          keep_nxt  = hit;
          which_nxt = 1'b0;
          state_nxt = ST_RESULT;
        end else if (hit && !stat.map_same) begin
          state_nxt = ST_DOT_RUN;
        end else begin
          keep_nxt  = 1'b1;
          which_nxt = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_DOT_RUN: begin
        cmd.dot_step = 1'b1;
        if (stat.k_last) begin
          state_nxt = ST_DOT_DRAIN;
        end
      end
      ST_DOT_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // mapped pair strictly closer: drop the new match, else free the entry
        cmd.map_clr = !stat.greater;
        keep_nxt    = !stat.greater;
        which_nxt   = 1'b1;
        state_nxt   = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      keep_r  <= 1'b0;
      which_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      keep_r  <= keep_nxt;
      which_r <= which_nxt;
    end
  end

  a_result_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register busy");

  a_decide_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE) |-> !stat.pipe_busy)
    else $error("decision taken with products still in flight");

endmodule

/* sv/mcr_datapath.sv */
// Datapath: item register, descriptor and map memories, two MAC lanes, result register.
module mcr_datapath #(
  parameter int MAX_FEATURES = mcr_pkg::MAX_FEATURES_DEF,
  parameter int DESC_LEN     = mcr_pkg::DESC_LEN_DEF,
  parameter int ELEM_BITS    = mcr_pkg::ELEM_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mcr_pkg::in_item_t  in_data,
  input  mcr_pkg::ctl_cmd_t  cmd,
  output mcr_pkg::ctl_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output mcr_pkg::out_item_t out_data
);

  localparam int MAP_AW  = $clog2(MAX_FEATURES);
  localparam int DESC_AW = $clog2(MAX_FEATURES * DESC_LEN);
  localparam int K_W     = $clog2(DESC_LEN);
  localparam int PROD_W  = 2 * ELEM_BITS;

  // signed zero keeps the product select signed
  localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

  mcr_pkg::in_item_t  item_r;
  mcr_pkg::out_item_t out_data_r;
  logic               out_valid_r;

  logic [DESC_AW-1:0] base_f1_r, base_f2_r, base_old_r;
  logic               old_ok_r;
  logic [K_W-1:0]     k_r;
  logic [MAP_AW-1:0]  sweep_cnt_r;
  logic               rd_vld_r, prod_vld_r;

  logic signed [PROD_W-1:0]          prod_old_r, prod_new_r;
  logic signed [mcr_pkg::ACC_W-1:0]  acc_old_r, acc_new_r;

  logic [MAP_AW-1:0]           map_addr;
  logic                        map_we;
  logic [MAP_AW-1:0]           map_wa;
  logic [mcr_pkg::MAP_W-1:0]   map_wd;
  logic [mcr_pkg::MAP_W-1:0]   map_q;
  logic [mcr_pkg::FEAT_W-1:0]  map_idx;

  logic signed [ELEM_BITS-1:0] wr_elem;
  logic [ELEM_BITS-1:0]        first_old_q, first_new_q, second_q;
  logic [DESC_AW-1:0]          kofs;

  assign map_addr = MAP_AW'(item_r.second_feature);
  assign map_idx  = map_q[mcr_pkg::FEAT_W-1:0];
  assign wr_elem  = ELEM_BITS'(item_r.value);   // sign-extend or wrap
  assign kofs     = DESC_AW'(k_r);

  // Map write port: clearing sweep, first-list set, or entry release
  assign map_we = cmd.sweep || cmd.map_set || cmd.map_clr;
  assign map_wa = cmd.sweep ? sweep_cnt_r : map_addr;
  assign map_wd = cmd.map_set ? {1'b1, item_r.first_feature} : '0;

  mcr_ram #(
    .WIDTH (mcr_pkg::MAP_W),
    .DEPTH (MAX_FEATURES)
  ) u_map (
    .clk       (clk),
    .wr_en     (map_we),
    .wr_addr   (map_wa),
    .wr_data   (map_wd),
    .rd_addr_a (map_addr),
    .rd_data_a (map_q),
    .rd_addr_b (map_addr),
    .rd_data_b ()
  );

  mcr_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (MAX_FEATURES * DESC_LEN)
  ) u_first_desc (
    .clk       (clk),
    .wr_en     (cmd.wr_first),
    .wr_addr   (base_f1_r + DESC_AW'(item_r.element)),
    .wr_data   (wr_elem),
    .rd_addr_a (base_old_r + kofs),
    .rd_data_a (first_old_q),
    .rd_addr_b (base_f1_r + kofs),
    .rd_data_b (first_new_q)
  );

  mcr_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (MAX_FEATURES * DESC_LEN)
  ) u_second_desc (
    .clk       (clk),
    .wr_en     (cmd.wr_second),
    .wr_addr   (base_f2_r + DESC_AW'(item_r.element)),
    .wr_data   (wr_elem),
    .rd_addr_a (base_f2_r + kofs),
    .rd_data_a (second_q),
    .rd_addr_b (base_f2_r + kofs),
    .rd_data_b ()
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.prep) begin
      base_f1_r <= DESC_AW'(item_r.first_feature) * DESC_AW'(DESC_LEN);
      base_f2_r <= DESC_AW'(item_r.second_feature) * DESC_AW'(DESC_LEN);
    end
    if (cmd.acc_clr) begin
      base_old_r <= DESC_AW'(map_idx) * DESC_AW'(DESC_LEN);
      old_ok_r   <= (32'(map_idx) < 32'(MAX_FEATURES));
    end
    // out-of-range first feature reads as an all-zero descriptor
    prod_old_r <= old_ok_r ? $signed(first_old_q) * $signed(second_q) : PROD_ZERO;
    prod_new_r <= stat.f1_ok ? $signed(first_new_q) * $signed(second_q) : PROD_ZERO;
    if (cmd.acc_clr) begin
      acc_old_r <= '0;
      acc_new_r <= '0;
    end else if (prod_vld_r) begin
      acc_old_r <= acc_old_r + mcr_pkg::ACC_W'(prod_old_r);
      acc_new_r <= acc_new_r + mcr_pkg::ACC_W'(prod_new_r);
    end
    if (cmd.out_load) begin
      out_data_r.keep       <= cmd.out_keep;
      out_data_r.which_list <= cmd.out_which;
      out_data_r.out_first  <= item_r.first_feature;
      out_data_r.out_second <= item_r.second_feature;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= '0;
      sweep_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      prod_vld_r  <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      k_r         <= cmd.dot_step ? k_r + 1'b1 : '0;
      sweep_cnt_r <= cmd.sweep ? sweep_cnt_r + 1'b1 : '0;
      rd_vld_r    <= cmd.dot_step;
      prod_vld_r  <= rd_vld_r;
    end
  end

  always_comb begin
    stat            = '0;
    stat.mode       = item_r.mode;
    stat.f1_ok      = (32'(item_r.first_feature) < 32'(MAX_FEATURES));
    stat.f2_ok      = (32'(item_r.second_feature) < 32'(MAX_FEATURES));
    stat.el_ok      = (32'(item_r.element) < 32'(DESC_LEN));
    stat.map_valid  = map_q[mcr_pkg::FEAT_W];
    stat.map_same   = (map_idx == item_r.first_feature);
    stat.k_last     = (k_r == K_W'(DESC_LEN - 1));
    stat.pipe_busy  = rd_vld_r || prod_vld_r;
    stat.sweep_last = (sweep_cnt_r == MAP_AW'(MAX_FEATURES - 1));
    stat.greater    = (acc_old_r > acc_new_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_map_port_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.sweep, cmd.map_set, cmd.map_clr}))
    else $error("map write port driven by two sources");

  a_clear_on_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_clr |-> !(rd_vld_r || prod_vld_r))
    else $error("accumulators cleared with products in flight");

  a_no_load_during_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_first || cmd.wr_second) |-> !(cmd.dot_step || rd_vld_r || prod_vld_r))
    else $error("descriptor written during a dot product");

  a_dot_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(cmd.dot_step) |-> ($past(stat.map_valid) && $past(stat.f2_ok)
                            && !$past(stat.map_same)))
    else $error("dot product started without a conflicting map entry");

endmodule

/* tb/match_conflict_resolver_test.sv */
// Self-checking testbench of the match conflict resolver, directed and random beats.
module match_conflict_resolver_test;

  localparam int DESC_LEN    = mcr_pkg::DESC_LEN_DEF;
  localparam int FEAT_W      = mcr_pkg::FEAT_W;
  localparam int MODE_W      = mcr_pkg::MODE_W;
  localparam int VALUE_W     = mcr_pkg::VALUE_W;
  localparam int ELEMP_W     = mcr_pkg::ELEMP_W;
  localparam int MAP_W       = mcr_pkg::MAP_W;
  // Longest quiet stretch of a correct run: a map sweep or the long receiver
  // hold, well under this.
  localparam int STALL_LIMIT = 20000;
  // Cycles after the last expected beat in which a stray result would show:
  // one full judging pass plus margin.
  localparam int DRAIN_WAIT  = DESC_LEN + 40;

  // Modes the block must swallow without a result
  localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  mcr_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mcr_pkg::out_item_t out_data;

  always #5 clk = ~clk;

  match_conflict_resolver DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the block state. Descriptor elements are keyed by
  // feature * DESC_LEN + element; the written masks tell which descriptors
  // are complete, since the block's descriptor memories are not cleared and
  // a read of an unwritten element must never be caused.
  // ---------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] first_elem  [int];
  logic signed [VALUE_W-1:0] second_elem [int];
  bit [DESC_LEN-1:0]         first_written  [int];
  bit [DESC_LEN-1:0]         second_written [int];
  logic [MAP_W-1:0]          pair_map [mcr_pkg::MAX_FEATURES_DEF] = '{default: '0};

  mcr_pkg::out_item_t expected_results [$];

  int fail_count   = 0;
  int tx_idle_pct  = 0;   // chance per cycle that the sender holds back
  int rx_stall_pct = 0;   // chance per cycle that the receiver stalls
  int rx_hold      = 0;   // cycles of forced receiver stall still to go
  int quiet_cycles = 0;

  // Features whose descriptors are loaded completely. Extreme indexes so that
  // every index bit toggles on the judged paths too.
  logic [FEAT_W-1:0] first_pool  [4] = '{12'h000, 12'hFFF, 12'h5A3, 12'hA5C};
  logic [FEAT_W-1:0] second_pool [3] = '{12'h000, 12'hFFF, 12'h3C5};

  function automatic bit desc_complete(bit second, logic [FEAT_W-1:0] feat);
    if (second) begin
      if (!second_written.exists(feat)) return 1'b0;
      return &second_written[feat];
    end
    if (!first_written.exists(feat)) return 1'b0;
    return &first_written[feat];
  endfunction

  // Exact dot product of a first and a second descriptor; cannot wrap at
  // these sizes (64 products of at most 2^30).
  function automatic longint dot_score(logic [FEAT_W-1:0] f1, logic [FEAT_W-1:0] f2);
    longint acc;
    int     k;
    acc = 0;
    for (k = 0; k < DESC_LEN; k++)
      acc += longint'(first_elem[int'(f1) * DESC_LEN + k]) *
             longint'(second_elem[int'(f2) * DESC_LEN + k]);
    return acc;
  endfunction

  // Applies one accepted beat to the local state. Returns 1 and fills res
  // when the beat produces a result.
  function automatic bit resolve_beat(mcr_pkg::in_item_t it, output mcr_pkg::out_item_t res);
    logic [MAP_W-1:0] entry;
    res            = '0;
    res.out_first  = it.first_feature;
    res.out_second = it.second_feature;
    entry          = pair_map[it.second_feature];
    case (it.mode)
      mcr_pkg::MODE_LOAD_FIRST: begin
        first_elem[int'(it.first_feature) * DESC_LEN + int'(it.element)] = it.value;
        if (!first_written.exists(it.first_feature)) first_written[it.first_feature] = '0;
        first_written[it.first_feature][it.element] = 1'b1;
        return 1'b0;
      end
      mcr_pkg::MODE_LOAD_SECOND: begin
        second_elem[int'(it.second_feature) * DESC_LEN + int'(it.element)] = it.value;
        if (!second_written.exists(it.second_feature)) second_written[it.second_feature] = '0;
        second_written[it.second_feature][it.element] = 1'b1;
        return 1'b0;
      end
      mcr_pkg::MODE_CLEAR_MAP: begin
        pair_map = '{default: '0};
        return 1'b0;
      end
      mcr_pkg::MODE_FIRST_MATCH: begin
        pair_map[it.second_feature] = {1'b1, it.first_feature};
        return 1'b0;
      end
      mcr_pkg::MODE_SECOND_MATCH: begin
        res.which_list = 1'b1;
        res.keep       = 1'b1;
        // Only a hit on a different mapped feature is judged; the old pair
        // wins only when strictly closer, a tie clears the entry.
        if (entry[FEAT_W] && entry[FEAT_W-1:0] != it.first_feature) begin
          if (dot_score(entry[FEAT_W-1:0], it.second_feature) >
              dot_score(it.first_feature, it.second_feature)) begin
            res.keep = 1'b0;
          end else begin
            pair_map[it.second_feature] = '0;
          end
        end
        return 1'b1;
      end
      mcr_pkg::MODE_RECHECK: begin
        res.which_list = 1'b0;
        res.keep       = entry[FEAT_W];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the beat until it is taken. Valid
  // is only lowered by an idle cycle or a pause, so back-to-back beats never
  // see a low and a high assigned in one step.
  // ---------------------------------------------------------------------------
  task automatic send_beat(mcr_pkg::in_item_t it);
    mcr_pkg::out_item_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (resolve_beat(it, res)) expected_results.push_back(res);
  endtask

  // Sender pause: nothing offered until every expected beat is in, then a
  // little longer to catch stray results.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic mcr_pkg::in_item_t make_beat(logic [MODE_W-1:0] mode,
                                                  logic [FEAT_W-1:0] f1,
                                                  logic [FEAT_W-1:0] f2);
    mcr_pkg::in_item_t it;
    it.mode           = mode;
    it.first_feature  = f1;
    it.second_feature = f2;
    it.element        = ELEMP_W'($urandom);
    it.value          = VALUE_W'($urandom);
    return it;
  endfunction

  // Random beat, mostly well-formed match traffic over the loaded pools.
  // A second-list match that would read an incomplete descriptor is turned
  // into a same-feature hit, which reads nothing.
  function automatic mcr_pkg::in_item_t random_beat();
    mcr_pkg::in_item_t it;
    int                roll;
    logic [MAP_W-1:0]  entry;
    it   = make_beat(mcr_pkg::MODE_RECHECK, FEAT_W'($urandom), FEAT_W'($urandom));
    roll = $urandom_range(99);
    if (roll < 15) begin
      it.mode = $urandom_range(1) ? mcr_pkg::MODE_LOAD_SECOND : mcr_pkg::MODE_LOAD_FIRST;
      if ($urandom_range(99) < 80) begin
        it.first_feature  = first_pool[$urandom_range(3)];
        it.second_feature = second_pool[$urandom_range(2)];
      end
    end else if (roll < 35) begin
      it.mode = mcr_pkg::MODE_FIRST_MATCH;
      if ($urandom_range(99) < 70) it.first_feature = first_pool[$urandom_range(3)];
      if ($urandom_range(99) < 70) it.second_feature = second_pool[$urandom_range(2)];
    end else if (roll < 75) begin
      it.mode = mcr_pkg::MODE_SECOND_MATCH;
      if ($urandom_range(99) < 85) it.first_feature = first_pool[$urandom_range(3)];
      if ($urandom_range(99) < 85) it.second_feature = second_pool[$urandom_range(2)];
      entry = pair_map[it.second_feature];
      if (entry[FEAT_W] && entry[FEAT_W-1:0] != it.first_feature &&
          !(desc_complete(1'b0, entry[FEAT_W-1:0]) && desc_complete(1'b0, it.first_feature) &&
            desc_complete(1'b1, it.second_feature)))
        it.first_feature = entry[FEAT_W-1:0];
    end else if (roll < 95) begin
      it.mode = mcr_pkg::MODE_RECHECK;
      if ($urandom_range(99) < 70) it.second_feature = second_pool[$urandom_range(2)];
    end else if (roll < 99) begin
      it.mode = $urandom_range(1) ? MODE_UNUSED_A : MODE_UNUSED_B;
    end else begin
      it.mode = mcr_pkg::MODE_CLEAR_MAP;
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a forced hold counted down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Result check: every taken beat against the oldest expectation.
  always @(posedge clk) begin
    mcr_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected, out_second",
                        out_data.out_second, -1);
      end else begin
        want = expected_results.pop_front();
        if (out_data.keep !== want.keep)
          report_mismatch("keep", out_data.keep, want.keep);
        if (out_data.which_list !== want.which_list)
          report_mismatch("which_list", out_data.which_list, want.which_list);
        if (out_data.out_first !== want.out_first)
          report_mismatch("out_first", out_data.out_first, want.out_first);
        if (out_data.out_second !== want.out_second)
          report_mismatch("out_second", out_data.out_second, want.out_second);
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic load_descriptor(logic [MODE_W-1:0] mode, logic [FEAT_W-1:0] feat,
                                 logic signed [VALUE_W-1:0] vec [DESC_LEN]);
    mcr_pkg::in_item_t it;
    for (int k = 0; k < DESC_LEN; k++) begin
      it         = make_beat(mode, feat, feat);
      it.element = ELEMP_W'(k);
      it.value   = vec[k];
      send_beat(it);
    end
  endtask

  // Complete descriptors for the pools: all-max and all-min give the extreme
  // products, the two shared first descriptors give exact ties.
  task automatic test_descriptor_setup();
    logic signed [VALUE_W-1:0] hi_vec [DESC_LEN];
    logic signed [VALUE_W-1:0] lo_vec [DESC_LEN];
    logic signed [VALUE_W-1:0] shared [DESC_LEN];
    logic signed [VALUE_W-1:0] mixed  [DESC_LEN];
    tx_idle_pct  = 7;
    rx_stall_pct = 7;
    for (int k = 0; k < DESC_LEN; k++) begin
      hi_vec[k] = 16'sh7FFF;
      lo_vec[k] = 16'sh8000;
      shared[k] = VALUE_W'($urandom);
      mixed[k]  = VALUE_W'($urandom);
    end
    load_descriptor(mcr_pkg::MODE_LOAD_FIRST,  12'h000, hi_vec);
    load_descriptor(mcr_pkg::MODE_LOAD_FIRST,  12'hFFF, lo_vec);
    load_descriptor(mcr_pkg::MODE_LOAD_FIRST,  12'h5A3, shared);
    load_descriptor(mcr_pkg::MODE_LOAD_FIRST,  12'hA5C, shared);
    load_descriptor(mcr_pkg::MODE_LOAD_SECOND, 12'h000, hi_vec);
    load_descriptor(mcr_pkg::MODE_LOAD_SECOND, 12'hFFF, lo_vec);
    load_descriptor(mcr_pkg::MODE_LOAD_SECOND, 12'h3C5, mixed);
    wait_for_results();
  endtask

  // One pass through each decision path; outcomes follow from the pools.
  task automatic test_directed_decisions();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'h000, 12'h000));  // never mapped
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'h000, 12'h000));  // empty entry
    send_beat(make_beat(mcr_pkg::MODE_FIRST_MATCH,  12'h000, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'h7A1, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'h000, 12'h000));  // same feature
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'hFFF, 12'h000));  // old closer, dropped
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'hFFF, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_FIRST_MATCH,  12'hFFF, 12'h000));  // overwrite entry
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'h000, 12'h000));  // new closer, cleared
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'h000, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_FIRST_MATCH,  12'h5A3, 12'h3C5));
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'hA5C, 12'h3C5));  // tie clears the entry
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'hA5C, 12'h3C5));
    send_beat(make_beat(mcr_pkg::MODE_FIRST_MATCH,  12'hFFF, 12'hFFF));  // min times min
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'h000, 12'hFFF));
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'hFFF, 12'hFFF));
    send_beat(make_beat(MODE_UNUSED_A,              12'hFFF, 12'hFFF));
    send_beat(make_beat(MODE_UNUSED_B,              12'hFFF, 12'hFFF));
    send_beat(make_beat(mcr_pkg::MODE_FIRST_MATCH,  12'hABC, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_CLEAR_MAP,    12'h000, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'h000, 12'hFFF));
    send_beat(make_beat(mcr_pkg::MODE_RECHECK,      12'h000, 12'h000));
    send_beat(make_beat(mcr_pkg::MODE_SECOND_MATCH, 12'h123, 12'h000));  // empty after clear
    wait_for_results();
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (count) send_beat(random_beat());
    wait_for_results();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the output register and the working slot fill and the input stalls.
  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold      = 400;
    repeat (40) send_beat(random_beat());
    wait_for_results();
  endtask

  // Short bursts, each followed by a full pause until the results are in.
  task automatic test_sender_pause();
    tx_idle_pct  = 0;
    rx_stall_pct = 30;
    repeat (3) begin
      repeat (20) send_beat(random_beat());
      wait_for_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_descriptor_setup();
    test_directed_decisions();
    test_random_traffic(345, 0, 0);
    test_output_backpressure();
    test_random_traffic(345, 59, 0);
    test_sender_pause();
    test_random_traffic(345, 0, 59);
    test_random_traffic(345, 7, 7);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
